// ----- src/ef_pkg.sv -----
// shared types, constants and fixed-point helpers for the flux jacobian block
package ef_pkg;

   localparam int FX_W    = 32;
   localparam int GAMMA_W = 18;

   typedef logic signed [FX_W-1:0] fx_type;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
   localparam fx_type FX_ONE  = 32'sd65536;
   localparam fx_type FX_TWO  = 32'sd131072;
   localparam fx_type FX_HALF = 32'sd32768;

   // one grid point as taken from the request channel
   typedef struct packed {
      fx_type q0;
      fx_type q1;
      fx_type q2;
      fx_type q3;
      fx_type jd;
      fx_type j1;
      fx_type ksi_x;
      fx_type ksi_y;
      fx_type eta_x;
      fx_type eta_y;
   } ef_point_type;

   // classified point handed from the front to the back
   typedef struct packed {
      fx_type u;
      fx_type v;
      fx_type a1;
      fx_type j1;
      fx_type ksi_x;
      fx_type ksi_y;
      fx_type eta_x;
      fx_type eta_y;
      logic   dz;
   } ef_job_type;

   // round to nearest (halves up) after the q16 shift, then saturate
   function automatic fx_type fx_round_sat(input logic signed [63:0] p);
      logic signed [63:0] s;
      logic signed [47:0] q;
      fx_type r;
      s = p + 64'sd32768;
      q = s[63:16];
      if (q[47:31] == {17{q[47]}}) begin
         r = q[31:0];
      end else if (q[47]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // saturate a 33 bit sum or difference
   function automatic fx_type fx_sat33(input logic signed [32:0] s);
      fx_type r;
      if (s[32] == s[31]) begin
         r = s[31:0];
      end else if (s[32]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// ----- src/ef_req_if.sv -----
// request channel: one grid point per handshake
interface ef_req_if;
   import ef_pkg::*;
   logic   valid;
   logic   ready;
   fx_type density_scaled;
   fx_type momentum_x_scaled;
   fx_type momentum_y_scaled;
   fx_type energy_scaled;
   fx_type jac_det;
   fx_type jac_scale;
   fx_type ksi_dx;
   fx_type ksi_dy;
   fx_type eta_dx;
   fx_type eta_dy;

   modport source (output valid, density_scaled, momentum_x_scaled, momentum_y_scaled,
                   energy_scaled, jac_det, jac_scale, ksi_dx, ksi_dy, eta_dx, eta_dy,
                   input ready);
   modport sink (input valid, density_scaled, momentum_x_scaled, momentum_y_scaled,
                 energy_scaled, jac_det, jac_scale, ksi_dx, ksi_dy, eta_dx, eta_dy,
                 output ready);
endinterface

// ----- src/ef_rsp_if.sv -----
// response channel: one matrix row per handshake
interface ef_rsp_if;
   import ef_pkg::*;
   logic       valid;
   logic       ready;
   logic       matrix_sel;
   logic [1:0] row_index;
   fx_type     col0;
   fx_type     col1;
   fx_type     col2;
   fx_type     col3;
   logic       div_zero;
   logic       last_row;

   modport source (output valid, matrix_sel, row_index, col0, col1, col2, col3,
                   div_zero, last_row, input ready);
   modport sink (input valid, matrix_sel, row_index, col0, col1, col2, col3,
                 div_zero, last_row, output ready);
endinterface

// ----- src/ef_div.sv -----
// radix-2 restoring divider for q16 quotients (a * 2^16) / b, truncating, saturated
module ef_div
   import ef_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   start,
   input  fx_type dividend,
   input  fx_type divisor,
   output logic   done,
   output fx_type quotient
);

   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   fx_type      res_ff, res_in;

   logic [32:0] trial;
   logic [31:0] mag_a;
   logic [31:0] mag_b;

   // operand magnitudes
   assign mag_a = dividend[31] ? 32'(-dividend) : 32'(dividend);
   assign mag_b = divisor[31] ? 32'(-divisor) : 32'(divisor);
   assign trial = {rem_ff, num_ff[47]};

   // one quotient bit per cycle, then sign and saturate
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {mag_a, 16'd0};
         rem_in  = '0;
         den_in  = mag_b;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            num_in = {num_ff[46:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            num_in = {num_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            res_in = (|num_ff[47:31]) ? 32'sh8000_0000 : -$signed(num_ff[31:0]);
         end else begin
            res_in = (|num_ff[47:31]) ? 32'sh7FFF_FFFF : $signed(num_ff[31:0]);
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// ----- src/ef_front.sv -----
// front end: takes a point, forms rho, e, u, v, a1 and the zero-density flag
module ef_front
   import ef_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [GAMMA_W-1:0] gamma,
   ef_req_if.sink             req,
   output logic               push,
   output ef_job_type         push_data,
   input  logic               q_full
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_MRHO = 11'b000_0000_0010,
      ST_RRHO = 11'b000_0000_0100,
      ST_ME   = 11'b000_0000_1000,
      ST_RE   = 11'b000_0001_0000,
      ST_DU   = 11'b000_0010_0000,
      ST_DV   = 11'b000_0100_0000,
      ST_DA   = 11'b000_1000_0000,
      ST_MA   = 11'b001_0000_0000,
      ST_RA   = 11'b010_0000_0000,
      ST_PUSH = 11'b100_0000_0000
   } st_type;

   st_type             state_ff, state_in;
   logic               in_full_ff, in_full_in;
   ef_point_type       in_pt_ff, in_pt_in;
   ef_point_type       pt_ff, pt_in;
   fx_type             rho_ff, rho_in;
   fx_type             e_ff, e_in;
   fx_type             quot_ff, quot_in;
   ef_job_type         job_ff, job_in;
   logic signed [63:0] prod_ff, prod_in;
   fx_type             mul_a, mul_b;
   fx_type             prod_r;

   logic   div_start;
   fx_type div_a, div_b;
   logic   div_done;
   fx_type div_q;

   ef_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req.ready = !in_full_ff;
   assign prod_r    = fx_round_sat(prod_ff);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      in_full_in = in_full_ff;
      in_pt_in   = in_pt_ff;
      pt_in      = pt_ff;
      rho_in     = rho_ff;
      e_in       = e_ff;
      quot_in    = quot_ff;
      job_in     = job_ff;
      mul_a      = pt_ff.jd;
      mul_b      = pt_ff.q0;
      div_start  = 1'b0;
      div_a      = pt_ff.q1;
      div_b      = pt_ff.q0;
      push       = 1'b0;

      // input holding register
      if (req.valid && !in_full_ff) begin
         in_full_in        = 1'b1;
         in_pt_in.q0       = req.density_scaled;
         in_pt_in.q1       = req.momentum_x_scaled;
         in_pt_in.q2       = req.momentum_y_scaled;
         in_pt_in.q3       = req.energy_scaled;
         in_pt_in.jd       = req.jac_det;
         in_pt_in.j1       = req.jac_scale;
         in_pt_in.ksi_x    = req.ksi_dx;
         in_pt_in.ksi_y    = req.ksi_dy;
         in_pt_in.eta_x    = req.eta_dx;
         in_pt_in.eta_y    = req.eta_dy;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_full_ff) begin
               pt_in      = in_pt_ff;
               in_full_in = 1'b0;
               state_in   = ST_MRHO;
            end
         end
         ST_MRHO: state_in = ST_RRHO;
         ST_RRHO: begin
            rho_in   = prod_r;
            mul_b    = pt_ff.q3;
            state_in = ST_ME;
         end
         // hold J*q3 in the product register until it is taken
         ST_ME: begin
            mul_b    = pt_ff.q3;
            state_in = ST_RE;
         end
         ST_RE: begin
            e_in         = prod_r;
            job_in.j1    = pt_ff.j1;
            job_in.ksi_x = pt_ff.ksi_x;
            job_in.ksi_y = pt_ff.ksi_y;
            job_in.eta_x = pt_ff.eta_x;
            job_in.eta_y = pt_ff.eta_y;
            job_in.u     = '0;
            job_in.v     = '0;
            job_in.a1    = '0;
            job_in.dz    = (pt_ff.q0 == '0) || (rho_ff == '0);
            if (job_in.dz) begin
               state_in = ST_PUSH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DU;
            end
         end
         ST_DU: begin
            div_a = pt_ff.q2;
            if (div_done) begin
               job_in.u  = div_q;
               div_start = 1'b1;
               state_in  = ST_DV;
            end
         end
         ST_DV: begin
            div_a = e_ff;
            div_b = rho_ff;
            if (div_done) begin
               job_in.v  = div_q;
               div_start = 1'b1;
               state_in  = ST_DA;
            end
         end
         ST_DA: begin
            if (div_done) begin
               quot_in  = div_q;
               state_in = ST_MA;
            end
         end
         ST_MA: begin
            mul_a    = fx_type'({14'd0, gamma});
            mul_b    = quot_ff;
            state_in = ST_RA;
         end
         ST_RA: begin
            job_in.a1 = prod_r;
            state_in  = ST_PUSH;
         end
         ST_PUSH: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      prod_in = mul_a * mul_b;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         in_full_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_full_ff <= in_full_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      in_pt_ff <= in_pt_in;
      pt_ff    <= pt_in;
      rho_ff   <= rho_in;
      e_ff     <= e_in;
      quot_ff  <= quot_in;
      job_ff   <= job_in;
      prod_ff  <= prod_in;
   end

   assign push_data = job_ff;

endmodule

// ----- src/ef_queue.sv -----
// two-entry queue between front and back
module ef_queue
   import ef_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  ef_job_type push_data,
   output logic       full,
   input  logic       pop,
   output ef_job_type pop_data,
   output logic       empty
);

   ef_job_type mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rptr_ff];

   // pointers and fill count
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/ef_back.sv -----
// back end: microcoded multiply/add sequencer building and sending the matrix rows
module ef_back
   import ef_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [GAMMA_W-1:0] gamma,
   input  logic               q_empty,
   input  ef_job_type         q_data,
   output logic               pop,
   ef_rsp_if.source           rsp
);

   typedef enum logic [2:0] {
      OP_MUL  = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_EMIT = 3'd3,
      OP_NEXT = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      R_ZERO, R_HALF, R_G, R_GM1, R_GM2, R_U, R_V, R_A1, R_J1, R_KX, R_KY,
      R_THETA, R_PHI2, R_T0, R_T1, R_T2, R_C0, R_C1, R_C2, R_C3
   } rsel_type;

   typedef struct packed {
      op_type   op;
      rsel_type a;
      rsel_type b;
      rsel_type d;
   } uop_type;

   localparam logic [6:0] PC_THETA = 7'd5;

   function automatic uop_type mk(input op_type op, input rsel_type a, input rsel_type b,
                                  input rsel_type d);
      uop_type u;
      u.op = op;
      u.a  = a;
      u.b  = b;
      u.d  = d;
      return u;
   endfunction

   // microprogram: shared terms, then per matrix theta and four rows
   function automatic uop_type rom(input logic [6:0] pc);
      uop_type u;
      unique case (pc)
         // phi2 for the point
         7'd0:  u = mk(OP_MUL, R_HALF, R_GM1, R_T0);
         7'd1:  u = mk(OP_MUL, R_U, R_U, R_T1);
         7'd2:  u = mk(OP_MUL, R_V, R_V, R_T2);
         7'd3:  u = mk(OP_ADD, R_T1, R_T2, R_T1);
         7'd4:  u = mk(OP_MUL, R_T0, R_T1, R_PHI2);
         // theta for this matrix
         7'd5:  u = mk(OP_MUL, R_KX, R_U, R_T0);
         7'd6:  u = mk(OP_MUL, R_KY, R_V, R_T1);
         7'd7:  u = mk(OP_ADD, R_T0, R_T1, R_THETA);
         // row 0
         7'd8:  u = mk(OP_ADD, R_ZERO, R_ZERO, R_C0);
         7'd9:  u = mk(OP_ADD, R_KX, R_ZERO, R_C1);
         7'd10: u = mk(OP_ADD, R_KY, R_ZERO, R_C2);
         7'd11: u = mk(OP_ADD, R_ZERO, R_ZERO, R_C3);
         7'd12: u = mk(OP_MUL, R_J1, R_C0, R_C0);
         7'd13: u = mk(OP_MUL, R_J1, R_C1, R_C1);
         7'd14: u = mk(OP_MUL, R_J1, R_C2, R_C2);
         7'd15: u = mk(OP_MUL, R_J1, R_C3, R_C3);
         7'd16: u = mk(OP_EMIT, R_ZERO, R_ZERO, R_ZERO);
         // row 1
         7'd17: u = mk(OP_MUL, R_KX, R_PHI2, R_T0);
         7'd18: u = mk(OP_MUL, R_U, R_THETA, R_T1);
         7'd19: u = mk(OP_SUB, R_T0, R_T1, R_C0);
         7'd20: u = mk(OP_MUL, R_GM2, R_KX, R_T0);
         7'd21: u = mk(OP_MUL, R_T0, R_U, R_T0);
         7'd22: u = mk(OP_SUB, R_THETA, R_T0, R_C1);
         7'd23: u = mk(OP_MUL, R_KY, R_U, R_T0);
         7'd24: u = mk(OP_MUL, R_GM1, R_KX, R_T1);
         7'd25: u = mk(OP_MUL, R_T1, R_V, R_T1);
         7'd26: u = mk(OP_SUB, R_T0, R_T1, R_C2);
         7'd27: u = mk(OP_MUL, R_GM1, R_KX, R_C3);
         7'd28: u = mk(OP_MUL, R_J1, R_C0, R_C0);
         7'd29: u = mk(OP_MUL, R_J1, R_C1, R_C1);
         7'd30: u = mk(OP_MUL, R_J1, R_C2, R_C2);
         7'd31: u = mk(OP_MUL, R_J1, R_C3, R_C3);
         7'd32: u = mk(OP_EMIT, R_ZERO, R_ZERO, R_ZERO);
         // row 2
         7'd33: u = mk(OP_MUL, R_KY, R_PHI2, R_T0);
         7'd34: u = mk(OP_MUL, R_V, R_THETA, R_T1);
         7'd35: u = mk(OP_SUB, R_T0, R_T1, R_C0);
         7'd36: u = mk(OP_MUL, R_KX, R_V, R_T0);
         7'd37: u = mk(OP_MUL, R_GM1, R_KY, R_T1);
         7'd38: u = mk(OP_MUL, R_T1, R_U, R_T1);
         7'd39: u = mk(OP_SUB, R_T0, R_T1, R_C1);
         7'd40: u = mk(OP_MUL, R_GM2, R_KY, R_T0);
         7'd41: u = mk(OP_MUL, R_T0, R_V, R_T0);
         7'd42: u = mk(OP_SUB, R_THETA, R_T0, R_C2);
         7'd43: u = mk(OP_MUL, R_GM1, R_KY, R_C3);
         7'd44: u = mk(OP_MUL, R_J1, R_C0, R_C0);
         7'd45: u = mk(OP_MUL, R_J1, R_C1, R_C1);
         7'd46: u = mk(OP_MUL, R_J1, R_C2, R_C2);
         7'd47: u = mk(OP_MUL, R_J1, R_C3, R_C3);
         7'd48: u = mk(OP_EMIT, R_ZERO, R_ZERO, R_ZERO);
         // row 3
         7'd49: u = mk(OP_SUB, R_PHI2, R_A1, R_T0);
         7'd50: u = mk(OP_MUL, R_THETA, R_T0, R_C0);
         7'd51: u = mk(OP_MUL, R_KX, R_A1, R_T0);
         7'd52: u = mk(OP_MUL, R_GM1, R_U, R_T1);
         7'd53: u = mk(OP_MUL, R_T1, R_THETA, R_T1);
         7'd54: u = mk(OP_SUB, R_T0, R_T1, R_C1);
         7'd55: u = mk(OP_MUL, R_KY, R_A1, R_T0);
         7'd56: u = mk(OP_MUL, R_GM1, R_V, R_T1);
         7'd57: u = mk(OP_MUL, R_T1, R_THETA, R_T1);
         7'd58: u = mk(OP_SUB, R_T0, R_T1, R_C2);
         7'd59: u = mk(OP_MUL, R_G, R_THETA, R_C3);
         7'd60: u = mk(OP_MUL, R_J1, R_C0, R_C0);
         7'd61: u = mk(OP_MUL, R_J1, R_C1, R_C1);
         7'd62: u = mk(OP_MUL, R_J1, R_C2, R_C2);
         7'd63: u = mk(OP_MUL, R_J1, R_C3, R_C3);
         7'd64: u = mk(OP_EMIT, R_ZERO, R_ZERO, R_ZERO);
         default: u = mk(OP_NEXT, R_ZERO, R_ZERO, R_ZERO);
      endcase
      return u;
   endfunction

   logic               busy_ff, busy_in;
   logic [6:0]         pc_ff, pc_in;
   logic               phase_ff, phase_in;
   logic               matrix_ff, matrix_in;
   logic [1:0]         row_ff, row_in;
   ef_job_type         job_ff, job_in;
   fx_type             theta_ff, theta_in;
   fx_type             phi2_ff, phi2_in;
   fx_type             t0_ff, t0_in;
   fx_type             t1_ff, t1_in;
   fx_type             t2_ff, t2_in;
   fx_type             c0_ff, c0_in;
   fx_type             c1_ff, c1_in;
   fx_type             c2_ff, c2_in;
   fx_type             c3_ff, c3_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_sel_ff, out_sel_in;
   logic [1:0]         out_row_ff, out_row_in;
   fx_type             out_c0_ff, out_c0_in;
   fx_type             out_c1_ff, out_c1_in;
   fx_type             out_c2_ff, out_c2_in;
   fx_type             out_c3_ff, out_c3_in;
   logic               out_dz_ff, out_dz_in;
   logic               out_last_ff, out_last_in;

   uop_type     uop;
   fx_type      g_fx, gm1_fx, gm2_fx;
   fx_type      opa, opb;
   fx_type      wval;
   logic        wen;
   logic        out_free;

   // register file read port
   function automatic fx_type rd(input rsel_type s, input fx_type g, input fx_type gm1,
                                 input fx_type gm2, input ef_job_type j, input logic m,
                                 input fx_type th, input fx_type ph, input fx_type r0,
                                 input fx_type r1, input fx_type r2, input fx_type k0,
                                 input fx_type k1, input fx_type k2, input fx_type k3);
      fx_type r;
      unique case (s)
         R_ZERO:  r = '0;
         R_HALF:  r = FX_HALF;
         R_G:     r = g;
         R_GM1:   r = gm1;
         R_GM2:   r = gm2;
         R_U:     r = j.u;
         R_V:     r = j.v;
         R_A1:    r = j.a1;
         R_J1:    r = j.j1;
         R_KX:    r = m ? j.eta_x : j.ksi_x;
         R_KY:    r = m ? j.eta_y : j.ksi_y;
         R_THETA: r = th;
         R_PHI2:  r = ph;
         R_T0:    r = r0;
         R_T1:    r = r1;
         R_T2:    r = r2;
         R_C0:    r = k0;
         R_C1:    r = k1;
         R_C2:    r = k2;
         R_C3:    r = k3;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign uop      = rom(pc_ff);
   assign g_fx     = fx_type'({14'd0, gamma});
   assign gm1_fx   = g_fx - FX_ONE;
   assign gm2_fx   = g_fx - FX_TWO;
   assign opa      = rd(uop.a, g_fx, gm1_fx, gm2_fx, job_ff, matrix_ff, theta_ff, phi2_ff,
                        t0_ff, t1_ff, t2_ff, c0_ff, c1_ff, c2_ff, c3_ff);
   assign opb      = rd(uop.b, g_fx, gm1_fx, gm2_fx, job_ff, matrix_ff, theta_ff, phi2_ff,
                        t0_ff, t1_ff, t2_ff, c0_ff, c1_ff, c2_ff, c3_ff);
   assign out_free = !out_valid_ff || rsp.ready;
   assign pop      = !busy_ff && !q_empty;

   // sequencer and execution
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      phase_in     = phase_ff;
      matrix_in    = matrix_ff;
      row_in       = row_ff;
      job_in       = job_ff;
      prod_in      = opa * opb;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_sel_in   = out_sel_ff;
      out_row_in   = out_row_ff;
      out_c0_in    = out_c0_ff;
      out_c1_in    = out_c1_ff;
      out_c2_in    = out_c2_ff;
      out_c3_in    = out_c3_ff;
      out_dz_in    = out_dz_ff;
      out_last_in  = out_last_ff;
      wen          = 1'b0;
      wval         = '0;

      if (pop) begin
         busy_in   = 1'b1;
         pc_in     = '0;
         phase_in  = 1'b0;
         matrix_in = 1'b0;
         row_in    = '0;
         job_in    = q_data;
      end else if (busy_ff) begin
         unique case (uop.op)
            OP_MUL: begin
               if (phase_ff) begin
                  wen      = 1'b1;
                  wval     = fx_round_sat(prod_ff);
                  phase_in = 1'b0;
                  pc_in    = pc_ff + 7'd1;
               end else begin
                  phase_in = 1'b1;
               end
            end
            OP_ADD: begin
               wen   = 1'b1;
               wval  = fx_sat33({opa[31], opa} + {opb[31], opb});
               pc_in = pc_ff + 7'd1;
            end
            OP_SUB: begin
               wen   = 1'b1;
               wval  = fx_sat33({opa[31], opa} - {opb[31], opb});
               pc_in = pc_ff + 7'd1;
            end
            OP_EMIT: begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_sel_in   = matrix_ff;
                  out_row_in   = row_ff;
                  out_c0_in    = job_ff.dz ? '0 : c0_ff;
                  out_c1_in    = job_ff.dz ? '0 : c1_ff;
                  out_c2_in    = job_ff.dz ? '0 : c2_ff;
                  out_c3_in    = job_ff.dz ? '0 : c3_ff;
                  out_dz_in    = job_ff.dz;
                  out_last_in  = matrix_ff && (row_ff == 2'd3);
                  row_in       = row_ff + 2'd1;
                  pc_in        = pc_ff + 7'd1;
               end
            end
            OP_NEXT: begin
               if (matrix_ff) begin
                  busy_in = 1'b0;
               end else begin
                  matrix_in = 1'b1;
                  row_in    = '0;
                  pc_in     = PC_THETA;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   // register file write port
   always_comb begin
      theta_in = theta_ff;
      phi2_in  = phi2_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      c0_in    = c0_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      c3_in    = c3_ff;
      if (wen) begin
         unique case (uop.d)
            R_THETA: theta_in = wval;
            R_PHI2:  phi2_in  = wval;
            R_T0:    t0_in    = wval;
            R_T1:    t1_in    = wval;
            R_T2:    t2_in    = wval;
            R_C0:    c0_in    = wval;
            R_C1:    c1_in    = wval;
            R_C2:    c2_in    = wval;
            R_C3:    c3_in    = wval;
            default: t2_in    = t2_ff;
         endcase
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         phase_ff     <= 1'b0;
         matrix_ff    <= 1'b0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         matrix_ff    <= matrix_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      prod_ff     <= prod_in;
      theta_ff    <= theta_in;
      phi2_ff     <= phi2_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      c3_ff       <= c3_in;
      out_sel_ff  <= out_sel_in;
      out_row_ff  <= out_row_in;
      out_c0_ff   <= out_c0_in;
      out_c1_ff   <= out_c1_in;
      out_c2_ff   <= out_c2_in;
      out_c3_ff   <= out_c3_in;
      out_dz_ff   <= out_dz_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.matrix_sel = out_sel_ff;
   assign rsp.row_index  = out_row_ff;
   assign rsp.col0       = out_c0_ff;
   assign rsp.col1       = out_c1_ff;
   assign rsp.col2       = out_c2_ff;
   assign rsp.col3       = out_c3_ff;
   assign rsp.div_zero   = out_dz_ff;
   assign rsp.last_row   = out_last_ff;

   // a new point always starts at the top of the program on matrix A
   a_pop_start: assert property (@(posedge clock) disable iff (reset)
      pop |=> busy_ff && (pc_ff == 7'd0) && !matrix_ff && (row_ff == 2'd0))
      else $error("point did not start at program entry");

   // last row flag only on row 3 of matrix B
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_sel_ff && (out_row_ff == 2'd3))
      else $error("last row flag on wrong row");

   // finishing matrix B releases the sequencer
   a_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (uop.op == OP_NEXT) && matrix_ff |=> !busy_ff)
      else $error("sequencer stayed busy after matrix B");

endmodule

// ----- src/euler2d_flux_jacobian.sv -----
// top level: 2D Euler flux jacobians A and B for one grid point per request
//
// Each request carries one grid point; the block answers with eight row responses,
// rows 0..3 of A (ksi) then rows 0..3 of B (eta), each entry scaled by jac_scale,
// signed Q16.16 with saturation. A zero density (q0 or J*q0) sets div_zero and
// forces the entries to zero. The front end forms rho, e and the three quotients
// with a one-bit-per-cycle divider; the back end runs a 66-step microprogram on a
// single multiply/add unit, a multiply writing back from its product register, so
// with the response side always ready that shared unit sets the sustained rate. A
// two-entry queue lets the front work on the next point while the back is busy, and
// an input holding register takes the next request during that time. The user is
// to write gamma through csr_wen/csr_wdata while idle; the block does not enforce it.
module euler2d_flux_jacobian
   import ef_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [GAMMA_W-1:0] csr_wdata,
   ef_req_if.sink             req,
   ef_rsp_if.source           rsp
);

   logic [GAMMA_W-1:0] gamma_ff, gamma_in;
   logic               q_push;
   ef_job_type         q_push_data;
   logic               q_full;
   logic               q_pop;
   ef_job_type         q_pop_data;
   logic               q_empty;

   // configuration register
   assign gamma_in = csr_wen ? csr_wdata : gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
      end else begin
         gamma_ff <= gamma_in;
      end
   end

   ef_front u_front (
      .clock     (clock),
      .reset     (reset),
      .gamma     (gamma_ff),
      .req       (req),
      .push      (q_push),
      .push_data (q_push_data),
      .q_full    (q_full)
   );

   ef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   ef_back u_back (
      .clock   (clock),
      .reset   (reset),
      .gamma   (gamma_ff),
      .q_empty (q_empty),
      .q_data  (q_pop_data),
      .pop     (q_pop),
      .rsp     (rsp)
   );

endmodule

// ----- verif/euler2d_flux_jacobian_tb.sv -----
// testbench for the 2D Euler flux jacobian block: directed table, random points, predictor check
`timescale 1ns / 100ps

module testbench;
   import ef_pkg::*;

   // one expected matrix row
   typedef struct {
      logic       sel;
      logic [1:0] row;
      fx_type     c [4];
      logic       dz;
      logic       last;
   } row_exp_type;

   // directed stimulus row; has_fixed marks rows with typed-in entries
   typedef struct {
      ef_point_type pt;
      logic         has_fixed;
      fx_type       fixed_val;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [GAMMA_W-1:0] csr_wdata = '0;

   ef_req_if req ();
   ef_rsp_if rsp ();

   euler2d_flux_jacobian dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   logic [GAMMA_W-1:0] gamma_model = GAMMA_RESET;
   row_exp_type        rows_pending [$];
   int                 fail_count = 0;
   int                 rows_seen = 0;
   int                 points_sent = 0;
   int                 zero_points = 0;
   int                 long_stall = 0;
   logic               stall_on = 1'b1;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // fixed-point arithmetic of the datapath
   function automatic fx_type sat64(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return fx_type'(x);
   endfunction

   function automatic fx_type qmul(input longint a, input longint b);
      return sat64((a * b + 32768) >>> 16);
   endfunction

   function automatic fx_type qdiv(input longint a, input longint b);
      return sat64((a * 65536) / b);
   endfunction

   function automatic fx_type qadd(input longint a, input longint b);
      return sat64(a + b);
   endfunction

   function automatic fx_type qsub(input longint a, input longint b);
      return sat64(a - b);
   endfunction

   // push the four rows of one jacobian for metric (kx, ky)
   task automatic push_jacobian(input logic sel, input logic dz, input fx_type kx,
                                input fx_type ky, input fx_type u, input fx_type v,
                                input fx_type a1, input fx_type j1);
      longint g, gm1, gm2;
      fx_type theta, phi2;
      fx_type m [4][4];
      row_exp_type r;
      g = longint'(gamma_model);
      gm1 = sat64(g - 65536);
      gm2 = sat64(g - 131072);
      theta = qadd(qmul(kx, u), qmul(ky, v));
      phi2 = qmul(qmul(32768, gm1), qadd(qmul(u, u), qmul(v, v)));
      m[0][0] = 0; m[0][1] = kx; m[0][2] = ky; m[0][3] = 0;
      m[1][0] = qsub(qmul(kx, phi2), qmul(u, theta));
      m[1][1] = qsub(theta, qmul(qmul(gm2, kx), u));
      m[1][2] = qsub(qmul(ky, u), qmul(qmul(gm1, kx), v));
      m[1][3] = qmul(gm1, kx);
      m[2][0] = qsub(qmul(ky, phi2), qmul(v, theta));
      m[2][1] = qsub(qmul(kx, v), qmul(qmul(gm1, ky), u));
      m[2][2] = qsub(theta, qmul(qmul(gm2, ky), v));
      m[2][3] = qmul(gm1, ky);
      m[3][0] = qmul(theta, qsub(phi2, a1));
      m[3][1] = qsub(qmul(kx, a1), qmul(qmul(gm1, u), theta));
      m[3][2] = qsub(qmul(ky, a1), qmul(qmul(gm1, v), theta));
      m[3][3] = qmul(g, theta);
      for (int i = 0; i < 4; i++) begin
         r.sel = sel;
         r.row = 2'(i);
         for (int k = 0; k < 4; k++) r.c[k] = dz ? fx_type'(0) : qmul(j1, m[i][k]);
         r.dz = dz;
         r.last = sel && (i == 3);
         rows_pending.push_back(r);
      end
   endtask

   // predict all eight rows of one grid point
   task automatic predict_point(input ef_point_type p);
      fx_type rho, e, u, v, a1;
      logic dz;
      rho = qmul(p.jd, p.q0);
      e = qmul(p.jd, p.q3);
      dz = (p.q0 == 0) || (rho == 0);
      u = 0; v = 0; a1 = 0;
      if (!dz) begin
         u = qdiv(p.q1, p.q0);
         v = qdiv(p.q2, p.q0);
         a1 = qmul(longint'(gamma_model), qdiv(e, rho));
      end
      if (dz) zero_points++;
      push_jacobian(1'b0, dz, p.ksi_x, p.ksi_y, u, v, a1, p.j1);
      push_jacobian(1'b1, dz, p.eta_x, p.eta_y, u, v, a1, p.j1);
   endtask

   // random gap, mostly short with an occasional long one
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   function automatic fx_type rnd_fx();
      case ($urandom_range(0, 5))
         0: return fx_type'($urandom);
         1: return 32'sh8000_0000;
         2: return 32'sh7FFF_FFFF;
         default: return fx_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   // plausible grid point with occasional extreme fields
   function automatic ef_point_type rnd_point();
      ef_point_type p;
      p.q0 = fx_type'($urandom_range(32'h0000_4000, 32'h0004_0000));
      if ($urandom_range(0, 3) == 0) p.q0 = -p.q0;
      p.q1 = fx_type'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      p.q2 = fx_type'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      p.q3 = fx_type'($urandom_range(32'h0000_8000, 32'h0008_0000));
      p.jd = fx_type'($urandom_range(32'h0000_4000, 32'h0004_0000));
      p.j1 = fx_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      p.ksi_x = fx_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      p.ksi_y = fx_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      p.eta_x = fx_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      p.eta_y = fx_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      if ($urandom_range(0, 4) == 0) begin
         p.q0 = rnd_fx(); p.q1 = rnd_fx(); p.q2 = rnd_fx(); p.q3 = rnd_fx();
         p.jd = rnd_fx(); p.j1 = rnd_fx(); p.ksi_x = rnd_fx(); p.ksi_y = rnd_fx();
         p.eta_x = rnd_fx(); p.eta_y = rnd_fx();
      end
      if ($urandom_range(0, 19) == 0) p.q0 = 0;
      if ($urandom_range(0, 19) == 0) p.jd = 0;
      return p;
   endfunction

   // send one request and predict it at acceptance; valid stays up when no gap follows
   task automatic send_point(input ef_point_type p, input int gap);
      req.valid <= 1'b1;
      req.density_scaled <= p.q0;
      req.momentum_x_scaled <= p.q1;
      req.momentum_y_scaled <= p.q2;
      req.energy_scaled <= p.q3;
      req.jac_det <= p.jd;
      req.jac_scale <= p.j1;
      req.ksi_dx <= p.ksi_x;
      req.ksi_dy <= p.ksi_y;
      req.eta_dx <= p.eta_x;
      req.eta_dy <= p.eta_y;
      do @(posedge clock); while (!req.ready);
      predict_point(p);
      points_sent++;
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // wait for all rows, then let the block settle before a register write
   task automatic drain();
      while (rows_pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_gamma(input logic [GAMMA_W-1:0] val);
      drain();
      csr_wen <= 1'b1;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      gamma_model = val;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int hold;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (long_stall) @(negedge clock);
            long_stall = 0;
         end else if (stall_on && $urandom_range(0, 2) == 0) begin
            hold = gap_len();
            if (hold > 0) begin
               rsp.ready <= 1'b0;
               repeat (hold) @(negedge clock);
            end
         end
         rsp.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // response check at the rising edge
   always @(posedge clock) begin
      row_exp_type x;
      logic bad;
      if (!reset && rsp.valid && rsp.ready) begin
         rows_seen++;
         if (rows_pending.size() == 0) begin
            $display("%0t: unexpected response row sel=%0d row=%0d", $time,
                     rsp.matrix_sel, rsp.row_index);
            fail_count++;
         end else begin
            x = rows_pending.pop_front();
            bad = (rsp.matrix_sel !== x.sel) || (rsp.row_index !== x.row) ||
                  (rsp.div_zero !== x.dz) || (rsp.last_row !== x.last);
            if (!x.dz)
               bad = bad || (rsp.col0 !== x.c[0]) || (rsp.col1 !== x.c[1]) ||
                     (rsp.col2 !== x.c[2]) || (rsp.col3 !== x.c[3]);
            if (bad) begin
               $display("%0t: mismatch exp sel=%0d row=%0d %h %h %h %h dz=%0d last=%0d",
                        $time, x.sel, x.row, x.c[0], x.c[1], x.c[2], x.c[3], x.dz, x.last);
               $display("%0t:          got sel=%0d row=%0d %h %h %h %h dz=%0d last=%0d",
                        $time, rsp.matrix_sel, rsp.row_index, rsp.col0, rsp.col1,
                        rsp.col2, rsp.col3, rsp.div_zero, rsp.last_row);
               fail_count++;
            end
         end
      end
   end

   // overall time limit
   initial begin
      #200ms;
      $display("euler2d_flux_jacobian test failed");
      $finish;
   end

   // stimulus
   initial begin
      dir_row_type dir [$];
      dir_row_type d;
      ef_point_type p;
      int gap;
      req.valid = 1'b0;
      req.density_scaled = 0; req.momentum_x_scaled = 0; req.momentum_y_scaled = 0;
      req.energy_scaled = 0; req.jac_det = 0; req.jac_scale = 0;
      req.ksi_dx = 0; req.ksi_dy = 0; req.eta_dx = 0; req.eta_dy = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed table: zero density, tiny rho, extremes, unit point
      d.has_fixed = 1'b0; d.fixed_val = 0;
      d.pt = '{default: 0};
      d.pt.jd = FX_ONE; d.pt.ksi_x = FX_ONE; d.has_fixed = 1'b1;
      dir.push_back(d);                                  // q0 zero
      d.pt = '{default: 32'sh7FFF_FFFF}; d.pt.q0 = 1; d.pt.jd = 1;
      dir.push_back(d);                                  // rho rounds to zero
      d.has_fixed = 1'b0;
      d.pt = '{default: FX_ONE};
      dir.push_back(d);
      d.pt = '{default: 32'sh7FFF_FFFF};
      dir.push_back(d);
      d.pt = '{default: 32'sh8000_0000};
      dir.push_back(d);
      d.pt = '{default: 32'sh8000_0000}; d.pt.q0 = 1;
      dir.push_back(d);
      d.pt = '{default: -FX_ONE}; d.pt.q3 = 32'sh7FFF_FFFF;
      dir.push_back(d);
      d.pt = '{default: 32'sh5555_5555}; d.pt.q0 = FX_HALF;
      dir.push_back(d);
      d.pt = '{default: 32'shAAAA_AAAA}; d.pt.jd = FX_TWO;
      dir.push_back(d);
      d.pt = '{default: FX_TWO}; d.pt.q0 = -1; d.pt.jd = -FX_ONE;
      dir.push_back(d);
      foreach (dir[i]) begin
         send_point(dir[i].pt, (i == dir.size() - 1) ? 1 : 0);
         if (dir[i].has_fixed) begin
            // zero density: every pending row flagged, with a zero column 1 entry
            foreach (rows_pending[k])
               if (!rows_pending[k].dz || rows_pending[k].c[1] != dir[i].fixed_val) begin
                  $display("%0t: mismatch exp dz=1 entries=0 got prediction otherwise",
                           $time);
                  fail_count++;
               end
         end
      end

      // gamma sweep with random points, including range extremes and out-of-range
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_gamma(18'd65536);
            1: write_gamma(18'd131072);
            2: write_gamma(18'h3FFFF);
            3: write_gamma(18'd0);
            default: write_gamma(GAMMA_RESET);
         endcase
         for (int n = 0; n < 50; n++) begin
            if (phase == 2 && n == 5) long_stall = 2000;
            if (n == 25) drain();
            gap = (phase == 1) ? 0 : gap_len();
            if ((n == 24 || n == 49) && gap == 0) gap = 1;
            send_point(rnd_point(), gap);
         end
      end

      // final drain
      while (rows_pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("covered %0d points (%0d with zero density), %0d rows, five gamma settings",
               points_sent, zero_points, rows_seen);
      if (fail_count == 0 && rows_pending.size() == 0)
         $display("euler2d_flux_jacobian test passed");
      else
         $display("euler2d_flux_jacobian test failed");
      $finish;
   end

endmodule
